### rtl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and constants for the range sum window engine.
// ----------------------------------------------------------------------------
package rsw_pkg;

    // element and sum widths
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 42;
    localparam int BOUND_W   = 11;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // default store depth
    localparam int DEPTH_DEFAULT = 1024;

    // packed stream widths, rounded up to whole bytes
    localparam int S_DATA_BITS = DATA_W + 2 * BOUND_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = SUM_W + STATUS_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // command codes carried on tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_BOUNDS = 2'd1,
        ST_FULL       = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WALK,
        SEQ_RESULT
    } seq_state_t;

endpackage

### rtl/rsw_ram.sv
// ----------------------------------------------------------------------------
// rsw_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/range_sum_window_engine.sv
// ----------------------------------------------------------------------------
// range_sum_window_engine
// Exact range sums over a store of signed 32-bit elements, kept with a
// sliding window whose ends walk one element per cycle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  tuser: cmd; tdata: value, bounds
//  m_        out        m_tvalid/m_tready  tdata: range_sum, status
//
//  load, clear, unused command and bad query go straight to the result state
//  good query: the window ends first walk to the query bounds, then the result;
//  the single store read port and the one 42-bit add/subtract unit take one
//  element a cycle
//  one item at a time; s_tready is high only while the sequencer is idle
//  a result waits in the output register while the next item is taken
//  reset is synchronous, active low; the store needs no clearing pass
// ----------------------------------------------------------------------------
module range_sum_window_engine #(
    parameter int DEPTH = rsw_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsw_pkg::S_TDATA_W-1:0]  s_tdata,   // value, left_bound, right_bound
    input  logic [rsw_pkg::CMD_W-1:0]      s_tuser,   // cmd
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rsw_pkg::M_TDATA_W-1:0]  m_tdata    // range_sum, status
);

    import rsw_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > BOUND_W) ? POS_W : BOUND_W;

    // state registers
    seq_state_t           state_reg,       state_next;
    logic [POS_W-1:0]     count_reg,       count_next;
    logic [POS_W-1:0]     win_start_reg,   win_start_next;
    logic [POS_W-1:0]     win_end_reg,     win_end_next;
    logic [SUM_W-1:0]     win_sum_reg,     win_sum_next;
    logic [POS_W-1:0]     tgt_start_reg,   tgt_start_next;
    logic [POS_W-1:0]     tgt_end_reg,     tgt_end_next;
    logic                 pend_valid_reg,  pend_valid_next;
    logic                 pend_sub_reg,    pend_sub_next;
    logic [SUM_W-1:0]     res_sum_reg,     res_sum_next;
    status_t              res_status_reg,  res_status_next;
    logic                 m_valid_reg,     m_valid_next;
    logic [SUM_W-1:0]     m_sum_reg,       m_sum_next;
    status_t              m_status_reg,    m_status_next;

    // store port signals
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]    ram_rdata;

    // input unpacking
    cmd_t                 in_cmd;
    logic [DATA_W-1:0]    in_value;
    logic [BOUND_W-1:0]   in_lb;
    logic [BOUND_W-1:0]   in_rb;
    logic [CMP_W-1:0]     lb_c;
    logic [CMP_W-1:0]     rb_c;
    logic [CMP_W-1:0]     cnt_c;

    // shared add/subtract unit
    logic [SUM_W-1:0]     elem_ext;
    logic [SUM_W-1:0]     addend;
    logic [SUM_W-1:0]     acc_sum;
    logic [POS_W-1:0]     start_dec;
    logic [POS_W-1:0]     end_dec;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_value = s_tdata[DATA_W-1:0];
    assign in_lb    = s_tdata[DATA_W +: BOUND_W];
    assign in_rb    = s_tdata[DATA_W + BOUND_W +: BOUND_W];
    assign lb_c     = CMP_W'(in_lb);
    assign rb_c     = CMP_W'(in_rb);
    assign cnt_c    = CMP_W'(count_reg);

    assign elem_ext  = {{(SUM_W - DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
    assign addend    = pend_sub_reg ? ~elem_ext : elem_ext;
    assign acc_sum   = win_sum_reg + addend + SUM_W'(pend_sub_reg);
    assign start_dec = win_start_reg - POS_W'(1);
    assign end_dec   = win_end_reg - POS_W'(1);

    // element store
    rsw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ports
    assign s_tready = (state_reg == SEQ_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_status_reg, m_sum_reg});

    // sequencer next state and datapath control
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        win_start_next  = win_start_reg;
        win_end_next    = win_end_reg;
        win_sum_next    = win_sum_reg;
        tgt_start_next  = tgt_start_reg;
        tgt_end_next    = tgt_end_reg;
        pend_valid_next = pend_valid_reg;
        pend_sub_next   = pend_sub_reg;
        res_sum_next    = res_sum_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_sum_next      = m_sum_reg;
        m_status_next   = m_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_wdata       = in_value;
        ram_re          = 1'b0;
        ram_raddr       = win_end_reg[ADDR_W-1:0];

        // result leaves on its transfer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_tvalid) begin
                    res_sum_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = SEQ_RESULT;
                    unique case (in_cmd)
                        CMD_LOAD: begin
                            if (count_reg == POS_W'(DEPTH)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + POS_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (lb_c == '0 || lb_c > rb_c || rb_c > cnt_c) begin
                                res_status_next = ST_BAD_BOUNDS;
                            end else begin
                                tgt_start_next = POS_W'(lb_c - CMP_W'(1));
                                tgt_end_next   = POS_W'(rb_c);
                                state_next     = SEQ_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next     = '0;
                            win_start_next = '0;
                            win_end_next   = '0;
                            win_sum_next   = '0;
                        end
                        CMD_NOP: begin
                        end
                    endcase
                end
            end

            SEQ_WALK: begin
                // fold in the element read last cycle
                if (pend_valid_reg) begin
                    win_sum_next = acc_sum;
                end
                pend_valid_next = 1'b1;
                // move one window end by one element
                if (win_end_reg < tgt_end_reg) begin
                    ram_re        = 1'b1;
                    ram_raddr     = win_end_reg[ADDR_W-1:0];
                    win_end_next  = win_end_reg + POS_W'(1);
                    pend_sub_next = 1'b0;
                end else if (win_start_reg < tgt_start_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = win_start_reg[ADDR_W-1:0];
                    win_start_next = win_start_reg + POS_W'(1);
                    pend_sub_next  = 1'b1;
                end else if (win_start_reg > tgt_start_reg) begin
                    ram_re         = 1'b1;
                    ram_raddr      = start_dec[ADDR_W-1:0];
                    win_start_next = start_dec;
                    pend_sub_next  = 1'b0;
                end else if (win_end_reg > tgt_end_reg) begin
                    ram_re        = 1'b1;
                    ram_raddr     = end_dec[ADDR_W-1:0];
                    win_end_next  = end_dec;
                    pend_sub_next = 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        res_sum_next = win_sum_reg;
                        state_next   = SEQ_RESULT;
                    end
                end
            end

            SEQ_RESULT: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_sum_next    = res_sum_reg;
                    m_status_next = res_status_reg;
                    state_next    = SEQ_IDLE;
                end
            end

            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            count_reg      <= '0;
            win_start_reg  <= '0;
            win_end_reg    <= '0;
            win_sum_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            win_start_reg  <= win_start_next;
            win_end_reg    <= win_end_next;
            win_sum_reg    <= win_sum_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tgt_start_reg  <= tgt_start_next;
        tgt_end_reg    <= tgt_end_next;
        pend_sub_reg   <= pend_sub_next;
        res_sum_reg    <= res_sum_next;
        res_status_reg <= res_status_next;
        m_sum_reg      <= m_sum_next;
        m_status_reg   <= m_status_next;
    end

    // window never inverts
    assert property (@(posedge aclk) disable iff (!aresetn)
        win_start_reg <= win_end_reg)
        else $error("window start passed window end");

    // window stays inside loaded elements
    assert property (@(posedge aclk) disable iff (!aresetn)
        win_end_reg <= count_reg)
        else $error("window end passed element count");

    // no store read left unfolded when a new item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending element at item acceptance");

    // a walk ends with the window on its target
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_WALK && state_next == SEQ_RESULT) |->
            (win_start_reg == tgt_start_reg && win_end_reg == tgt_end_reg))
        else $error("walk finished off target");

endmodule

### test/tb_range_sum_window_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_sum_window_engine
// Self-checking bench for the range sum window engine. Loads, range queries,
// clears and unused commands are streamed in, and every result is compared
// against a window-walking prediction kept in step with accepted items.
// Directed cases cover the element and bound extremes, bad bounds, a full
// store and a long output stall. These are followed by random load/query
// sequences under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_range_sum_window_engine;

    import rsw_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int CLK_HALF   = 6;
    localparam int TAIL_WAIT  = 20;
    localparam int WATCHDOG   = 4_000_000;

    // one result, holding the range_sum and status fields of m_tdata
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        status_t                 status;
    } range_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // value, left_bound, right_bound
    logic [CMD_W-1:0]       s_tuser  = CMD_NOP;   // cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;   // range_sum, status

    // expected results in arrival order
    range_result_t          pending_sums[$];
    int                     error_count = 0;

    // idle and stall percentages of the current phase
    int                     src_idle_pct  = 0;
    int                     dst_stall_pct = 0;
    // long output hold-off, counted down by the receiver
    int                     hold_cycles   = 0;

    // predicted store and window
    logic signed [DATA_W-1:0] elem_store [DEPTH];
    int unsigned              elem_count;
    int unsigned              win_start;
    int unsigned              win_end;
    logic signed [SUM_W-1:0]  win_sum;

    range_result_t          got_result;
    range_result_t          want_result;

    range_sum_window_engine #(
        .DEPTH (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #(CLK_HALF) aclk = ~aclk;

    // expected result of one accepted item; walks the window like the block
    function automatic range_result_t predict_range_sum(input cmd_t cmd,
                                                       input logic [DATA_W-1:0] value,
                                                       input logic [BOUND_W-1:0] lb,
                                                       input logic [BOUND_W-1:0] rb);
        range_result_t r;
        int unsigned   first;
        int unsigned   stop;
        r.sum    = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_LOAD: begin
                if (elem_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    elem_store[elem_count] = value;
                    elem_count++;
                end
            end
            CMD_QUERY: begin
                if (lb < 1 || lb > rb || rb > elem_count) begin
                    r.status = ST_BAD_BOUNDS;
                end else begin
                    first = lb - 1;
                    stop  = rb;
                    while (win_end < stop) begin
                        win_sum += elem_store[win_end];
                        win_end++;
                    end
                    while (win_start < first) begin
                        win_sum -= elem_store[win_start];
                        win_start++;
                    end
                    while (win_start > first) begin
                        win_start--;
                        win_sum += elem_store[win_start];
                    end
                    while (win_end > stop) begin
                        win_end--;
                        win_sum -= elem_store[win_end];
                    end
                    r.sum = win_sum;
                end
            end
            CMD_CLEAR: begin
                elem_count = 0;
                win_start  = 0;
                win_end    = 0;
                win_sum    = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly random elements, now and then an extreme one
    function automatic logic [DATA_W-1:0] pick_element();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // send one item; starts and ends on a falling edge
    task automatic send_item(input cmd_t cmd, input logic [DATA_W-1:0] value,
                             input logic [BOUND_W-1:0] lb, input logic [BOUND_W-1:0] rb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({rb, lb, value});
        do @(posedge aclk); while (!s_tready);
        pending_sums.push_back(predict_range_sum(cmd, value, lb, rb));
        @(negedge aclk);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    // element extremes, bound extremes, bad bounds, unused command, clear
    task automatic test_basic_ranges();
        send_item(CMD_CLEAR, '0, '0, '0);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1);          // empty store
        send_item(CMD_LOAD, 32'h7FFF_FFFF, '0, '0);
        send_item(CMD_LOAD, 32'h8000_0000, '0, '0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
        send_item(CMD_LOAD, 32'h0000_0000, '0, '0);
        send_item(CMD_LOAD, 32'h0000_0001, '0, '0);
        send_item(CMD_QUERY, '0, 11'd1, 11'd5);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1);
        send_item(CMD_QUERY, '0, 11'd2, 11'd2);
        send_item(CMD_QUERY, '0, 11'd2, 11'd4);
        send_item(CMD_QUERY, '0, 11'd5, 11'd5);
        send_item(CMD_QUERY, 32'hFFFF_FFFF, 11'd1, 11'd5);
        send_item(CMD_QUERY, '0, 11'd0, 11'd3);          // left bound zero
        send_item(CMD_QUERY, '0, 11'd4, 11'd3);          // left past right
        send_item(CMD_QUERY, '0, 11'd1, 11'd6);          // right past count
        send_item(CMD_QUERY, '0, 11'h7FF, 11'h7FF);
        send_item(CMD_NOP, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
        send_item(CMD_QUERY, '0, 11'd3, 11'd3);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1);          // store emptied
        send_item(CMD_LOAD, 32'h1234_5678, '0, '0);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1);
    endtask

    // fill the whole store, overrun it, then query its ends and past them
    task automatic test_store_full();
        send_item(CMD_CLEAR, '0, '0, '0);
        for (int i = 0; i < DEPTH; i++)
            send_item(CMD_LOAD, (i % 2 == 0) ? 32'h8000_0000 : pick_element(),
                      BOUND_W'($urandom), BOUND_W'($urandom));
        send_item(CMD_LOAD, 32'h7FFF_FFFF, '0, '0);      // dropped
        send_item(CMD_QUERY, '0, 11'd1, 11'd1024);
        send_item(CMD_QUERY, '0, 11'd1024, 11'd1024);
        send_item(CMD_QUERY, '0, 11'd512, 11'd513);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1);
        send_item(CMD_QUERY, '0, 11'd1, 11'd1025);
        send_item(CMD_CLEAR, '0, '0, '0);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 8; i++)
            send_item(CMD_LOAD, pick_element(), BOUND_W'($urandom), BOUND_W'($urandom));
        send_item(CMD_QUERY, '0, 11'd1, 11'd8);
        send_item(CMD_QUERY, '0, 11'd3, 11'd6);
        send_item(CMD_NOP, $urandom, BOUND_W'($urandom), BOUND_W'($urandom));
        send_item(CMD_QUERY, '0, 11'd9, 11'd9);
    endtask

    // random load runs followed by queries, with some noise and broken queries
    task automatic test_random_mix(input int n_items);
        int sent;
        int n_loads;
        int n_queries;
        int lb;
        int rb;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0 || elem_count > 300) begin
                send_item(CMD_CLEAR, $urandom, BOUND_W'($urandom), BOUND_W'($urandom));
                sent++;
            end
            n_loads = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
            repeat (n_loads) begin
                send_item(CMD_LOAD, pick_element(), BOUND_W'($urandom), BOUND_W'($urandom));
                sent++;
            end
            n_queries = $urandom_range(2, 10);
            repeat (n_queries) begin
                case ($urandom_range(9))
                    0: send_item(cmd_t'($urandom_range(3)), pick_element(),
                                 BOUND_W'($urandom), BOUND_W'($urandom));
                    1: send_item(CMD_QUERY, $urandom, BOUND_W'($urandom),
                                 BOUND_W'($urandom));
                    2: begin
                        lb = $urandom_range(2, 2047);
                        send_item(CMD_QUERY, $urandom, BOUND_W'(lb),
                                  BOUND_W'($urandom_range(0, lb - 1)));
                    end
                    default: begin
                        if (elem_count == 0) begin
                            send_item(CMD_QUERY, $urandom, 11'd1, 11'd1);
                        end else begin
                            lb = $urandom_range(1, elem_count);
                            rb = lb + $urandom_range(0, 40);
                            if (rb > elem_count)
                                rb = elem_count;
                            send_item(CMD_QUERY, $urandom, BOUND_W'(lb), BOUND_W'(rb));
                        end
                    end
                endcase
                sent++;
            end
        end
    endtask

    // receiver ready, with random stalls and the long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.sum    = m_tdata[SUM_W-1:0];
            got_result.status = status_t'(m_tdata[SUM_W +: STATUS_W]);
            if (pending_sums.size() == 0) begin
                $error("unexpected result: range_sum %0d status %0d",
                       got_result.sum, got_result.status);
                error_count++;
            end else begin
                want_result = pending_sums.pop_front();
                if (got_result.sum !== want_result.sum) begin
                    $error("range_sum mismatch: expected %0d, got %0d",
                           want_result.sum, got_result.sum);
                    error_count++;
                end
                if (got_result.status !== want_result.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want_result.status, got_result.status);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        elem_count = 0;
        win_start  = 0;
        win_end    = 0;
        win_sum    = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_ranges();
        test_store_full();
        test_output_backpressure();

        src_idle_pct  = 0;
        dst_stall_pct = 0;
        test_random_mix(110);
        src_idle_pct  = 58;
        dst_stall_pct = 0;
        test_random_mix(110);
        src_idle_pct  = 0;
        dst_stall_pct = 58;
        test_random_mix(110);
        src_idle_pct  = 32;
        dst_stall_pct = 32;
        test_random_mix(120);

        wait_for_results();
        if (error_count == 0 && pending_sums.size() == 0) begin
            $display("range_sum_window_engine test passed");
        end else begin
            $display("range_sum_window_engine test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (WATCHDOG) @(posedge aclk);
        $display("range_sum_window_engine test failed");
        $finish;
    end

endmodule

### files.f
rtl/rsw_pkg.sv
rtl/rsw_ram.sv
rtl/range_sum_window_engine.sv
test/tb_range_sum_window_engine.sv
